[rtl/ibfc_pkg.sv]
// Package for the input boost frequency controller.
// Holds event and mode codes, register indexes, widths and shared structs.
// No dependencies.
`default_nettype none

package ibfc_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int DUR_W              = 16;
    localparam int FREQ_W             = 24;
    localparam int OP_W               = 3;
    localparam int MODE_W             = 2;
    localparam int CFG_IDX_W          = 3;

    // event codes
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_INPUT  = 3'd1;
    localparam logic [OP_W-1:0] OP_KICK   = 3'd2;
    localparam logic [OP_W-1:0] OP_SUSP   = 3'd3;
    localparam logic [OP_W-1:0] OP_RESUME = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd5;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INPUT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_DUR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_DUR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_LIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_BIG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_BIG    = 3'd5;

    localparam logic [DUR_W-1:0]  INPUT_DUR_RST = 16'd200;
    localparam logic [DUR_W-1:0]  WAKE_DUR_RST  = 16'd500;
    localparam logic [FREQ_W-1:0] FULL_SCALE    = 24'hFFFFFF;

    typedef struct packed {
        logic [DUR_W-1:0]  input_duration;
        logic [DUR_W-1:0]  wake_duration;
        logic [FREQ_W-1:0] boost_freq_little;
        logic [FREQ_W-1:0] boost_freq_big;
        logic [FREQ_W-1:0] idle_freq_little;
        logic [FREQ_W-1:0] idle_freq_big;
    } cfg_t;

    typedef struct packed {
        logic              within_input;
        logic [MODE_W-1:0] mode;
        logic [FREQ_W-1:0] freq_big;
        logic [FREQ_W-1:0] freq_little;
    } result_t;

endpackage

`default_nettype wire

[rtl/input_boost_frequency_controller_top.sv]
// Top level of the input boost frequency controller.
// Holds the configuration registers and a two-entry result buffer.
// Depends on ibfc_pkg and ibfc_core.
//
//  channel  | direction | tdata (low bit up)                         | tuser
//  s_axis   | in        | max_duration[15:0], query_timeout[31:16]   | op[2:0]
//  m_axis   | out       | freq_little[23:0], freq_big[47:24],        | mode[1:0]
//           |           | within_input[48], zero pad to 56 bits      |
//  cfg      | in        | cfg_index selects register, cfg_data value | -
//
// One word per cycle while s_axis_tready is high; each result is registered on m_axis.
// The event update and result select sit between the state registers and the result register.
// Reset clears state and loads register defaults (200, 500, then zeros).
// A skid register takes one more word while m_axis stalls; s_axis_tready drops when it is full.
`default_nettype none

module input_boost_frequency_controller_top #(
    parameter int TIMER_BITS = ibfc_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [31:0]                       s_axis_tdata,  // max_duration, query_timeout
    input  wire logic [ibfc_pkg::OP_W-1:0]         s_axis_tuser,  // op
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [55:0]                            m_axis_tdata,  // freq_little, freq_big, within_input
    output logic [ibfc_pkg::MODE_W-1:0]            m_axis_tuser,  // mode
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ibfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ibfc_pkg::FREQ_W-1:0]       cfg_data
);
    import ibfc_pkg::*;

    cfg_t    cfg_reg;
    result_t res_comb;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    accept, pop;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_duration    <= INPUT_DUR_RST;
            cfg_reg.wake_duration     <= WAKE_DUR_RST;
            cfg_reg.boost_freq_little <= '0;
            cfg_reg.boost_freq_big    <= '0;
            cfg_reg.idle_freq_little  <= '0;
            cfg_reg.idle_freq_big     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INPUT_DUR: cfg_reg.input_duration    <= cfg_data[DUR_W-1:0];
                REG_WAKE_DUR:  cfg_reg.wake_duration     <= cfg_data[DUR_W-1:0];
                REG_BOOST_LIT: cfg_reg.boost_freq_little <= cfg_data;
                REG_BOOST_BIG: cfg_reg.boost_freq_big    <= cfg_data;
                REG_IDLE_LIT:  cfg_reg.idle_freq_little  <= cfg_data;
                REG_IDLE_BIG:  cfg_reg.idle_freq_big     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ibfc_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .op            (s_axis_tuser),
        .max_duration  (s_axis_tdata[15:0]),
        .query_timeout (s_axis_tdata[31:16]),
        .cfg           (cfg_reg),
        .result        (res_comb)
    );

    // output word plus one skid word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res_comb;
        end
        else if (accept)
        begin
            if (out_valid_reg)
                skid_reg <= res_comb;
            else
                out_reg <= res_comb;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.within_input, out_reg.freq_big, out_reg.freq_little};
    assign m_axis_tuser  = out_reg.mode;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_off_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == MODE_OFF |-> m_axis_tdata[47:0] == '0)
        else $error("screen off result with nonzero frequency");

    a_max_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == MODE_MAX
        |-> m_axis_tdata[23:0] == FULL_SCALE && m_axis_tdata[47:24] == FULL_SCALE)
        else $error("max boost result not at full scale");

endmodule

`default_nettype wire

[rtl/ibfc_core.sv]
// Boost state: screen-off flag, two countdown timers, ticks since input.
// Applies one event per cycle while accept is high and forms the result from the updated state.
// Depends on ibfc_pkg.
`default_nettype none

module ibfc_core #(
    parameter int TIMER_BITS = ibfc_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [ibfc_pkg::OP_W-1:0]     op,
    input  wire logic [ibfc_pkg::DUR_W-1:0]    max_duration,
    input  wire logic [ibfc_pkg::DUR_W-1:0]    query_timeout,
    input  wire ibfc_pkg::cfg_t                cfg,
    output ibfc_pkg::result_t                  result
);
    import ibfc_pkg::*;

    localparam int W     = TIMER_BITS;
    localparam int CMP_W = (W > DUR_W) ? W : DUR_W;

    logic         screen_off_reg, screen_off_next;
    logic [W-1:0] input_rem_reg, input_rem_next;
    logic [W-1:0] max_rem_reg, max_rem_next;
    logic [W-1:0] since_reg, since_next;

    logic [DUR_W-1:0] kick_dur;
    logic [W-1:0]     kick_want;
    logic [W-1:0]     input_load;
    logic [CMP_W-1:0] since_cmp, timeout_cmp;

    assign kick_dur = (op == OP_RESUME) ? cfg.wake_duration : max_duration;

    // durations wider than the timer saturate
    generate
        if (W > DUR_W) begin : g_wide
            assign kick_want  = W'(kick_dur);
            assign input_load = W'(cfg.input_duration);
        end else if (W == DUR_W) begin : g_equal
            assign kick_want  = kick_dur;
            assign input_load = cfg.input_duration;
        end else begin : g_narrow
            assign kick_want  = (|kick_dur[DUR_W-1:W]) ? '1 : kick_dur[W-1:0];
            assign input_load = (|cfg.input_duration[DUR_W-1:W]) ? '1
                                : cfg.input_duration[W-1:0];
        end
    endgenerate

    always_comb
    begin
        screen_off_next = screen_off_reg;
        input_rem_next  = input_rem_reg;
        max_rem_next    = max_rem_reg;
        since_next      = since_reg;
        if (accept)
        begin
            unique case (op)
                OP_TICK:
                begin
                    if (input_rem_reg != '0)
                        input_rem_next = input_rem_reg - 1'b1;
                    if (max_rem_reg != '0)
                        max_rem_next = max_rem_reg - 1'b1;
                    if (since_reg != '1)
                        since_next = since_reg + 1'b1;
                end
                OP_INPUT:
                begin
                    if (!screen_off_reg && cfg.input_duration != '0)
                        input_rem_next = input_load;
                    since_next = '0;
                end
                OP_KICK:
                begin
                    if (!screen_off_reg && !(max_rem_reg > kick_want))
                        max_rem_next = kick_want;
                end
                OP_SUSP:
                begin
                    screen_off_next = 1'b1;
                end
                OP_RESUME:
                begin
                    screen_off_next = 1'b0;
                    if (!(max_rem_reg > kick_want))
                        max_rem_next = kick_want;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_off_reg <= 1'b0;
            input_rem_reg  <= '0;
            max_rem_reg    <= '0;
            since_reg      <= '0;
        end
        else
        begin
            screen_off_reg <= screen_off_next;
            input_rem_reg  <= input_rem_next;
            max_rem_reg    <= max_rem_next;
            since_reg      <= since_next;
        end
    end

    assign since_cmp   = CMP_W'(since_next);
    assign timeout_cmp = CMP_W'(query_timeout);

    always_comb
    begin
        if (screen_off_next)
        begin
            result.freq_little = '0;
            result.freq_big    = '0;
            result.mode        = MODE_OFF;
        end
        else if (max_rem_next != '0)
        begin
            result.freq_little = FULL_SCALE;
            result.freq_big    = FULL_SCALE;
            result.mode        = MODE_MAX;
        end
        else if (input_rem_next != '0)
        begin
            result.freq_little = cfg.boost_freq_little;
            result.freq_big    = cfg.boost_freq_big;
            result.mode        = MODE_INPUT;
        end
        else
        begin
            result.freq_little = cfg.idle_freq_little;
            result.freq_big    = cfg.idle_freq_big;
            result.mode        = MODE_IDLE;
        end
        result.within_input = (since_next != '1) && (since_cmp < timeout_cmp);
    end

    a_input_clears_since: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == OP_INPUT |=> since_reg == '0)
        else $error("since-input count not cleared by input event");

    a_suspend_sets_off: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == OP_SUSP |=> screen_off_reg)
        else $error("suspend did not set screen off");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(max_rem_reg) && $stable(input_rem_reg) && $stable(since_reg))
        else $error("state moved without an accepted word");

endmodule

`default_nettype wire
